>>> rtl/cvfp_pkg.sv
// ----------------------------------------------------------------------------
// cvfp_pkg
// Shared types, constants and helpers for the cell voltage frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cvfp_pkg;

	// frame layout constants
	localparam int unsigned MAX_CELLS   = 8;
	localparam int unsigned CELL_IDX_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned VALUE_W     = 16;

	localparam logic [7:0] SYNC_A      = 8'h0a;
	localparam logic [7:0] SYNC_B      = 8'hf5;
	localparam logic [7:0] SYNC_C      = 8'h0c;
	localparam logic [7:0] CLOSE_BYTE  = 8'h0d;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;

	localparam logic [CNT_W-1:0] MAX_CELLS_C = CNT_W'(MAX_CELLS);

	// result kinds
	localparam logic KIND_CELL  = 1'b0;
	localparam logic KIND_TRAIL = 1'b1;

	// controller states
	typedef enum logic [3:0] {
		ST_HUNT,
		ST_SYNC_B,
		ST_SYNC_C,
		ST_EXTRA,
		ST_COUNT,
		ST_CELLS,
		ST_TRAIL,
		ST_CLOSE,
		ST_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic start_frame;  // clear cell counter and hex group
		logic hold_extra;   // capture extra byte
		logic hold_count;   // capture announced cell count
		logic take_cell;    // feed a character to a cell group
		logic take_trail;   // feed a character to the trailing group
		logic start_emit;   // rewind the result index
		logic emit_load;    // load next result into output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic byte_sync_a;
		logic byte_sync_b;
		logic byte_sync_c;
		logic byte_zero;
		logic byte_close;
		logic count_ok;
		logic group_done;   // current character completes a 4-char group
		logic cells_done;   // completing group is the last announced cell
		logic emit_more;    // cell results still to be emitted
		logic out_free;     // output register can take a result
	} status_t;

	// hex character decode: {digit_ok, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]})) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/cvfp_ctrl.sv
// ----------------------------------------------------------------------------
// cvfp_ctrl
// Frame controller: sync hunt, header, text phases and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_ready,
	input  wire cvfp_pkg::status_t sts,
	output cvfp_pkg::cmd_t         cmd
);
	import cvfp_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   acc;

	assign rx_ready = (state_q != ST_EMIT);
	assign acc      = rx_valid && rx_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_HUNT: begin
				if (acc && sts.byte_sync_a) state_nxt = ST_SYNC_B;
			end
			ST_SYNC_B: begin
				if (acc) state_nxt = sts.byte_sync_b ? ST_SYNC_C : ST_HUNT;
			end
			ST_SYNC_C: begin
				if (acc) state_nxt = sts.byte_sync_c ? ST_EXTRA : ST_HUNT;
			end
			ST_EXTRA: begin
				if (acc) state_nxt = sts.byte_zero ? ST_HUNT : ST_COUNT;
			end
			ST_COUNT: begin
				if (acc) state_nxt = sts.count_ok ? ST_CELLS : ST_HUNT;
			end
			ST_CELLS: begin
				if (acc) begin
					if (sts.byte_zero) state_nxt = ST_HUNT;
					else if (sts.group_done && sts.cells_done) state_nxt = ST_TRAIL;
				end
			end
			ST_TRAIL: begin
				if (acc) begin
					if (sts.byte_zero) state_nxt = ST_HUNT;
					else if (sts.group_done) state_nxt = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (acc) state_nxt = sts.byte_close ? ST_EMIT : ST_HUNT;
			end
			ST_EMIT: begin
				// trailing word goes out last, then back to hunting
				if (sts.out_free && !sts.emit_more) state_nxt = ST_HUNT;
			end
			default: state_nxt = ST_HUNT;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_HUNT:  cmd.start_frame = acc && sts.byte_sync_a;
			ST_EXTRA: cmd.hold_extra  = acc && !sts.byte_zero;
			ST_COUNT: cmd.hold_count  = acc && sts.count_ok;
			ST_CELLS: cmd.take_cell   = acc && !sts.byte_zero;
			ST_TRAIL: cmd.take_trail  = acc && !sts.byte_zero;
			ST_CLOSE: cmd.start_emit  = acc && sts.byte_close;
			ST_EMIT:  cmd.emit_load   = sts.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/cvfp_dp.sv
// ----------------------------------------------------------------------------
// cvfp_dp
// Datapath: byte classification, hex group assembly, cell store and the
// result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfp_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [7:0]                       rx_byte,
	input  wire cvfp_pkg::cmd_t                   cmd,
	output cvfp_pkg::status_t                     sts,
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output logic                                  kind,
	output logic [cvfp_pkg::CELL_IDX_W-1:0]       cell_index,
	output logic [cvfp_pkg::VALUE_W-1:0]          value,
	output logic [cvfp_pkg::CNT_W-1:0]            cell_count,
	output logic [7:0]                            extra_byte,
	output logic                                  last
);
	import cvfp_pkg::*;

	// frame state
	logic [1:0]         digit_cnt_q;
	logic [CNT_W-1:0]   cell_cnt_q;
	logic [CNT_W-1:0]   announced_q;
	logic [7:0]         extra_q;
	logic [VALUE_W-1:0] partial_q;
	logic               hex_ended_q;
	logic [VALUE_W-1:0] trail_q;
	logic [VALUE_W-1:0] cell_store_q [MAX_CELLS];
	logic [CNT_W-1:0]   emit_idx_q;

	// output register
	logic                  res_valid_q;
	logic                  kind_q;
	logic [CELL_IDX_W-1:0] cell_index_q;
	logic [VALUE_W-1:0]    value_q;
	logic [CNT_W-1:0]      cell_count_q;
	logic [7:0]            extra_byte_q;
	logic                  last_q;

	logic [4:0]         hex;
	logic [VALUE_W-1:0] partial_nxt;
	logic               hex_ended_nxt;
	logic [7:0]         count_val;
	logic [CNT_W-1:0]   cell_cnt_inc;
	logic               take;

	// byte classification
	assign hex       = hex_decode(rx_byte);
	assign count_val = rx_byte - ASCII_ZERO;

	// next value of the hex group for this character
	always_comb begin
		partial_nxt   = partial_q;
		hex_ended_nxt = hex_ended_q;
		if (!hex_ended_q && hex[4]) begin
			partial_nxt = {partial_q[VALUE_W-5:0], hex[3:0]};
		end else begin
			hex_ended_nxt = 1'b1;
		end
	end

	assign cell_cnt_inc = cell_cnt_q + CNT_W'(1);
	assign take         = cmd.take_cell || cmd.take_trail;

	// status to controller
	always_comb begin
		sts.byte_sync_a = (rx_byte == SYNC_A);
		sts.byte_sync_b = (rx_byte == SYNC_B);
		sts.byte_sync_c = (rx_byte == SYNC_C);
		sts.byte_zero   = (rx_byte == 8'h00);
		sts.byte_close  = (rx_byte == CLOSE_BYTE);
		sts.count_ok    = (rx_byte != 8'h00) && (count_val != 8'h00)
		                  && (count_val <= 8'(MAX_CELLS));
		sts.group_done  = (digit_cnt_q == 2'd3);
		sts.cells_done  = (cell_cnt_inc >= announced_q);
		sts.emit_more   = (emit_idx_q < announced_q);
		sts.out_free    = !res_valid_q || res_ready;
	end

	// frame header, group and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_cnt_q <= '0;
			cell_cnt_q  <= '0;
			announced_q <= '0;
			extra_q     <= '0;
			partial_q   <= '0;
			hex_ended_q <= 1'b0;
			trail_q     <= '0;
			emit_idx_q  <= '0;
		end else begin
			if (cmd.start_frame) begin
				cell_cnt_q  <= '0;
				digit_cnt_q <= '0;
				partial_q   <= '0;
				hex_ended_q <= 1'b0;
			end
			if (cmd.hold_extra) extra_q <= rx_byte;
			if (cmd.hold_count) announced_q <= count_val[CNT_W-1:0];
			if (take) begin
				if (sts.group_done) begin
					digit_cnt_q <= '0;
					partial_q   <= '0;
					hex_ended_q <= 1'b0;
				end else begin
					digit_cnt_q <= digit_cnt_q + 2'd1;
					partial_q   <= partial_nxt;
					hex_ended_q <= hex_ended_nxt;
				end
			end
			if (cmd.take_cell && sts.group_done) cell_cnt_q <= cell_cnt_inc;
			if (cmd.take_trail && sts.group_done) trail_q <= partial_nxt;
			if (cmd.start_emit) begin
				emit_idx_q <= '0;
			end else if (cmd.emit_load && sts.emit_more) begin
				emit_idx_q <= emit_idx_q + CNT_W'(1);
			end
		end
	end

	// cell store, written when a cell group completes
	always_ff @(posedge clk) begin
		if (cmd.take_cell && sts.group_done && (cell_cnt_q < MAX_CELLS_C)) begin
			cell_store_q[cell_cnt_q[CELL_IDX_W-1:0]] <= partial_nxt;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload; header fields are held here so a new frame
	// header cannot disturb a request that is still waiting
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			cell_count_q <= announced_q;
			extra_byte_q <= extra_q;
			if (sts.emit_more) begin
				kind_q       <= KIND_CELL;
				cell_index_q <= emit_idx_q[CELL_IDX_W-1:0];
				value_q      <= cell_store_q[emit_idx_q[CELL_IDX_W-1:0]];
				last_q       <= 1'b0;
			end else begin
				kind_q       <= KIND_TRAIL;
				cell_index_q <= '0;
				value_q      <= trail_q;
				last_q       <= 1'b1;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign kind       = kind_q;
	assign cell_index = cell_index_q;
	assign value      = value_q;
	assign cell_count = cell_count_q;
	assign extra_byte = extra_byte_q;
	assign last       = last_q;

endmodule

`default_nettype wire

>>> rtl/cell_voltage_frame_parser_core.sv
// Emission: accepting the closing byte moves the controller into its emit state,
// which loads the first result into the output register. Throughput: one byte per
// cycle while a frame is parsed; after an accepted frame the byte input stalls while
// the cell results and trailing word are loaded, and while the result sink stalls.
// Reset: asynchronous, active low; clears controller, counters and output valid.
// The cell store has no reset; only entries written in the current frame are read.
// ----------------------------------------------------------------------------
// cell_voltage_frame_parser_core
// Byte stream frame parser emitting one request per cell plus a trailing word.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_voltage_frame_parser_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rx_valid,
	output logic                               rx_ready,
	input  wire logic [7:0]                    rx_byte,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic                               kind,
	output logic [cvfp_pkg::CELL_IDX_W-1:0]    cell_index,
	output logic [cvfp_pkg::VALUE_W-1:0]       value,
	output logic [cvfp_pkg::CNT_W-1:0]         cell_count,
	output logic [7:0]                         extra_byte,
	output logic                               last
);
	import cvfp_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// frame controller
	cvfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	cvfp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.kind       (kind),
		.cell_index (cell_index),
		.value      (value),
		.cell_count (cell_count),
		.extra_byte (extra_byte),
		.last       (last)
	);

	// only the trailing word request closes a frame
	a_last_is_trail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (kind == last))
		else $error("last flag does not match trailing word kind");

	// cell requests stay within the announced count
	a_cell_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (kind == KIND_CELL)) |-> (CNT_W'(cell_index) < cell_count))
		else $error("cell index beyond announced cell count");

	// input held off while a frame is still being emitted
	a_emit_blocks_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !last) |-> !rx_ready)
		else $error("byte input open before trailing word loaded");

endmodule

`default_nettype wire

>>> verif/cell_voltage_frame_parser_core_tb.sv
// ----------------------------------------------------------------------------
// cell_voltage_frame_parser_core_tb
// Drives serial bytes into the frame parser and checks every emitted request
// against a byte-level tracker of the frame syntax. A short directed stream
// covers the sync, count and hex text corner cases. Random frames follow,
// most of them well formed and some damaged or wrapped in line noise. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_voltage_frame_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cvfp_pkg::*;

	localparam int RANDOM_BYTES   = 370;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 20;

	// one emitted request as seen on the result port
	typedef struct {
		logic                  kind;
		logic [CELL_IDX_W-1:0] cell_index;
		logic [VALUE_W-1:0]    value;
		logic [CNT_W-1:0]      cell_count;
		logic [7:0]            extra_byte;
		logic                  last;
	} frame_entry_t;

	// Follows the frame syntax byte by byte and queues the readings that an
	// accepted frame must produce.
	class cell_frame_tracker;
		state_t             phase;
		logic [1:0]         chars_taken;
		logic [3:0]         cells_taken;
		logic [3:0]         cells_announced;
		logic [7:0]         extra_held;
		logic [VALUE_W-1:0] group_value;
		bit                 group_ended;
		logic [VALUE_W-1:0] cell_mv [MAX_CELLS];
		logic [VALUE_W-1:0] trail_word;
		frame_entry_t       pending_readings[$];
		int                 mismatches;

		function new();
			phase = ST_HUNT;
			cells_taken = '0;
			cells_announced = '0;
			extra_held = '0;
			trail_word = '0;
			foreach (cell_mv[i]) cell_mv[i] = '0;
			mismatches = 0;
			clear_group();
		endfunction

		function void clear_group();
			chars_taken = '0;
			group_value = '0;
			group_ended = 1'b0;
		endfunction

		// ASCII hex digit decode, either case
		function bit hex_digit(input logic [7:0] c, output logic [3:0] nib);
			nib = 4'h0;
			if (c >= ASCII_ZERO && c <= 8'h39) begin
				nib = 4'(c - ASCII_ZERO);
				return 1'b1;
			end
			if (c >= 8'h61 && c <= 8'h66) begin
				nib = 4'(c - 8'h61 + 8'd10);
				return 1'b1;
			end
			if (c >= 8'h41 && c <= 8'h46) begin
				nib = 4'(c - 8'h41 + 8'd10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// leading hex digits build the value; returns 1 on the fourth char
		function bit take_text(input logic [7:0] c);
			logic [3:0] nib;
			bit         is_hex;
			is_hex = hex_digit(c, nib);
			if (!group_ended && is_hex) begin
				group_value = {group_value[VALUE_W-5:0], nib};
			end else begin
				group_ended = 1'b1;
			end
			if (chars_taken == 2'd3) return 1'b1;
			chars_taken = chars_taken + 2'd1;
			return 1'b0;
		endfunction

		function void queue_reading(input logic kind, input int idx,
				input logic [VALUE_W-1:0] val, input logic is_last);
			frame_entry_t e;
			e.kind       = kind;
			e.cell_index = CELL_IDX_W'(idx);
			e.value      = val;
			e.cell_count = cells_announced;
			e.extra_byte = extra_held;
			e.last       = is_last;
			pending_readings.push_back(e);
		endfunction

		// one accepted byte request
		function void note_byte(input logic [7:0] c);
			logic [7:0] count_off;
			count_off = c - ASCII_ZERO;
			case (phase)
				ST_HUNT: begin
					if (c == SYNC_A) begin
						phase = ST_SYNC_B;
						cells_taken = '0;
						clear_group();
					end
				end
				ST_SYNC_B: phase = (c == SYNC_B) ? ST_SYNC_C : ST_HUNT;
				ST_SYNC_C: phase = (c == SYNC_C) ? ST_EXTRA : ST_HUNT;
				ST_EXTRA: begin
					if (c != 8'h00) begin
						extra_held = c;
						phase = ST_COUNT;
					end else begin
						phase = ST_HUNT;
					end
				end
				ST_COUNT: begin
					if (c != 8'h00 && count_off != 8'h00 && count_off <= MAX_CELLS) begin
						cells_announced = count_off[3:0];
						phase = ST_CELLS;
					end else begin
						phase = ST_HUNT;
					end
				end
				ST_CELLS: begin
					if (c == 8'h00) begin
						phase = ST_HUNT;
					end else if (take_text(c)) begin
						if (cells_taken < MAX_CELLS) cell_mv[cells_taken] = group_value;
						cells_taken = cells_taken + 4'd1;
						clear_group();
						if (cells_taken >= cells_announced) phase = ST_TRAIL;
					end
				end
				ST_TRAIL: begin
					if (c == 8'h00) begin
						phase = ST_HUNT;
					end else if (take_text(c)) begin
						trail_word = group_value;
						clear_group();
						phase = ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					// the closing byte never restarts a hunt by itself
					phase = ST_HUNT;
					if (c == CLOSE_BYTE) begin
						for (int i = 0; i < cells_announced && i < MAX_CELLS; i++) begin
							queue_reading(KIND_CELL, i, cell_mv[i], 1'b0);
						end
						queue_reading(KIND_TRAIL, 0, trail_word, 1'b1);
					end
				end
				default: phase = ST_HUNT;
			endcase
		endfunction

		// one accepted result request against the oldest pending reading
		function void check_reading(input frame_entry_t got);
			frame_entry_t want;
			if (pending_readings.size() == 0) begin
				$error("result with nothing pending: kind %0d value %0h", got.kind, got.value);
				mismatches++;
				return;
			end
			want = pending_readings.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0h, got %0h", want.kind, got.kind);
				mismatches++;
			end
			if (got.cell_index !== want.cell_index) begin
				$error("cell_index: expected %0h, got %0h", want.cell_index, got.cell_index);
				mismatches++;
			end
			if (got.value !== want.value) begin
				$error("value: expected %0h, got %0h", want.value, got.value);
				mismatches++;
			end
			if (got.cell_count !== want.cell_count) begin
				$error("cell_count: expected %0h, got %0h", want.cell_count, got.cell_count);
				mismatches++;
			end
			if (got.extra_byte !== want.extra_byte) begin
				$error("extra_byte: expected %0h, got %0h", want.extra_byte, got.extra_byte);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0h, got %0h", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  rx_valid = 1'b0;
	logic                  rx_ready;
	logic [7:0]            rx_byte = 8'h00;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic                  kind;
	logic [CELL_IDX_W-1:0] cell_index;
	logic [VALUE_W-1:0]    value;
	logic [CNT_W-1:0]      cell_count;
	logic [7:0]            extra_byte;
	logic                  last;

	cell_frame_tracker tracker;
	frame_entry_t      seen_entry;
	int                bytes_sent = 0;
	bit                sender_calm = 1'b0;
	bit                sink_calm = 1'b0;
	int                sink_stall = 0;
	int                idle_cycles = 0;

	// directed stream: ignored bytes, broken sync, zero extra, bad count, hex text
	logic [7:0] directed_bytes[$] = '{
		8'h00, 8'hff,
		SYNC_A, 8'h00,
		SYNC_A, SYNC_B, SYNC_A,
		SYNC_A, SYNC_B, SYNC_C, 8'h00,
		SYNC_A, SYNC_B, SYNC_C, 8'hff, 8'h39,
		SYNC_A, SYNC_B, SYNC_C, 8'h01, 8'h31,
		8'h41, 8'h66, 8'h67, 8'h39,
		8'h78, 8'h31, 8'h32, 8'h33,
		CLOSE_BYTE
	};

	cell_voltage_frame_parser_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.kind       (kind),
		.cell_index (cell_index),
		.value      (value),
		.cell_count (cell_count),
		.extra_byte (extra_byte),
		.last       (last)
	);

	always #6 clk = ~clk;

	// mostly short pauses, now and then a long one
	function automatic int idle_len();
		return ($urandom_range(0, 4) != 0) ? $urandom_range(1, 3) : $urandom_range(5, 40);
	endfunction

	function automatic logic [7:0] any_byte_but(input logic [7:0] avoid);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == avoid);
		return c;
	endfunction

	// one byte request, with an optional gap ahead of it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (sender_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		tracker.note_byte(b);
		bytes_sent++;
	endtask

	// hold the byte input off until every pending reading has come out
	task automatic drain_readings();
		rx_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_readings.size() != 0);
	endtask

	// result side: check accepted requests, stall at random
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			seen_entry = '{kind, cell_index, value, cell_count, extra_byte, last};
			tracker.check_reading(seen_entry);
		end
		if (sink_stall != 0) begin
			res_ready  <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
			res_ready  <= 1'b0;
			sink_stall <= idle_len() - 1;
		end else begin
			res_ready <= 1'b1;
		end
		if ($urandom_range(0, 149) == 0) sink_calm <= !sink_calm;
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if ((rx_valid && rx_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] frame[$];
		int         n_cells;
		int         pick;
		logic [7:0] c;
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
		drain_readings();

		while (bytes_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 5) == 0) sender_calm = !sender_calm;

			// line noise between frames
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end

			// well-formed frame, mostly few cells
			n_cells = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3)
				: $urandom_range(4, MAX_CELLS);
			frame = '{SYNC_A, SYNC_B, SYNC_C, 8'($urandom_range(1, 255)),
				8'(ASCII_ZERO + n_cells)};
			repeat (n_cells + 1) begin
				pick = $urandom_range(0, 9);
				for (int k = 0; k < 4; k++) begin
					if (pick == 0) begin
						c = 8'h46;
					end else if (pick == 1) begin
						c = ASCII_ZERO;
					end else if ($urandom_range(0, 7) != 0) begin
						// hex digit, either case
						c = 8'($urandom_range(0, 21));
						c = (c < 10) ? ASCII_ZERO + c
							: (c < 16) ? 8'h61 + c - 8'd10 : 8'h41 + c - 8'd16;
					end else begin
						// any non-zero byte, usually ending the value
						c = 8'($urandom_range(1, 255));
					end
					frame.push_back(c);
				end
			end
			frame.push_back(CLOSE_BYTE);

			// now and then damage the frame
			case ($urandom_range(0, 15))
				10: frame[1] = any_byte_but(SYNC_B);
				11: frame[2] = any_byte_but(SYNC_C);
				12: frame[3] = 8'h00;
				13: begin
					do c = 8'($urandom_range(0, 255));
					while (c > ASCII_ZERO && c <= ASCII_ZERO + MAX_CELLS);
					frame[4] = c;
				end
				14: frame[$urandom_range(5, frame.size() - 2)] = 8'h00;
				15: frame[frame.size() - 1] = $urandom_range(0, 1) ? SYNC_A
					: any_byte_but(CLOSE_BYTE);
				default: ;
			endcase

			foreach (frame[i]) send_byte(frame[i]);
			if ($urandom_range(0, 7) == 0) drain_readings();
		end

		rx_valid <= 1'b0;
		while (tracker.pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
